// ----- sv/rayg_pkg.sv -----
// ----------------------------------------------------------------------------
// rayg_pkg
// Shared widths, register indexes and side-band types of the pinhole camera
// ray generator.
// ----------------------------------------------------------------------------
package rayg_pkg;

   // Fixed-point format and screen limits
   localparam int FRAC_BITS  = 14;
   localparam int MAX_SCREEN = 4096;

   // Port field widths
   localparam int SCR_W  = 13;
   localparam int PIX_W  = 12;
   localparam int VEC_W  = 48;
   localparam int COMP_W = 16;
   localparam int DIST_W = 16;
   localparam int DIR_W  = 16;

   // Datapath widths
   localparam int UP_W     = 2 * COMP_W + 1;   // cross product component
   localparam int HD_W     = SCR_W + DIST_W + 1;
   localparam int VSUM_W   = 62;               // direction before normalizing
   localparam int MAG_W    = VSUM_W - 1;
   localparam int POS_W    = 6;
   localparam int NORM_W   = 30;               // normalized magnitude
   localparam int NORM_TOP = NORM_W - 1;
   localparam int SUM_W    = 2 * NORM_W + 2;   // sum of three squares
   localparam int ROOT_W   = SUM_W / 2;
   localparam int REM_W    = SUM_W + 2;
   localparam int NUM_W    = NORM_W + FRAC_BITS + 1;
   localparam int QUO_W    = FRAC_BITS + 1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH     = 3'd0,
      CSR_SCREEN_HEIGHT    = 3'd1,
      CSR_RIGHT_VECTOR     = 3'd2,
      CSR_FORWARD_VECTOR   = 3'd3,
      CSR_PINHOLE_DISTANCE = 3'd4
   } csr_index_type;

   // Side band that rides along the square root
   typedef struct packed {
      logic [2:0][NORM_W-1:0] mag;
      logic [2:0]             neg;
      logic                   degen;
   } norm_side_type;

   // Side band that rides along the divider
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } sign_side_type;

endpackage

// ----- sv/pinhole_camera_ray_generator_top.sv -----
// Throughput: one item per cycle; 8 front stages, a 31-stage square root
// (one root bit per stage), a rounding stage, a 15-stage divider and the
// output register. A stalled result freezes the whole pipeline in place.
// Reset clears every valid bit and loads the default camera: 640x480,
// right = +x, forward = +y, pinhole distance 1.0.
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator_top
// Primary ray direction for one pixel: builds the scaled view vector, then
// normalizes it to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator_top import rayg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VEC_W-1:0]     csr_data,
   // pixel items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_x,
   input  logic [PIX_W-1:0]     req_pixel_y,
   // ray items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DIR_W-1:0]     rsp_dir_x,
   output logic [DIR_W-1:0]     rsp_dir_y,
   output logic [DIR_W-1:0]     rsp_dir_z,
   output logic                 rsp_degenerate
);

   // Configuration registers
   logic [SCR_W-1:0]  width_ff, height_ff;
   logic [VEC_W-1:0]  right_ff, forward_ff;
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= SCR_W'(640);
         height_ff  <= SCR_W'(480);
         right_ff   <= VEC_W'(16384);
         forward_ff <= VEC_W'(1073741824);
         dist_ff    <= DIST_W'(4096);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:     width_ff   <= csr_data[SCR_W-1:0];
            CSR_SCREEN_HEIGHT:    height_ff  <= csr_data[SCR_W-1:0];
            CSR_RIGHT_VECTOR:     right_ff   <= csr_data;
            CSR_FORWARD_VECTOR:   forward_ff <= csr_data;
            CSR_PINHOLE_DISTANCE: dist_ff    <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the screen size
   logic [SCR_W-1:0] w_clamp, h_clamp;
   always_comb begin
      w_clamp = (width_ff > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : width_ff;
      priority if (height_ff > SCR_W'(MAX_SCREEN)) begin
         h_clamp = SCR_W'(MAX_SCREEN);
      end else if (height_ff == '0) begin
         h_clamp = SCR_W'(1);
      end else begin
         h_clamp = height_ff;
      end
   end

   // Unpack the camera vectors
   logic signed [COMP_W-1:0] r_comp [3];
   logic signed [COMP_W-1:0] f_comp [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_comp[k] = $signed(right_ff[COMP_W*k +: COMP_W]);
         f_comp[k] = $signed(forward_ff[COMP_W*k +: COMP_W]);
      end
   end

   // Derive up = cross(right, forward) and 2*H*d from the registers
   logic signed [UP_W-1:0] up_in [3];
   logic signed [UP_W-1:0] up_ff [3];
   logic [HD_W-2:0]        hd_prod;
   logic [HD_W-1:0]        hd_ff;

   always_comb begin
      up_in[0] = UP_W'(r_comp[1] * f_comp[2]) - UP_W'(r_comp[2] * f_comp[1]);
      up_in[1] = UP_W'(r_comp[2] * f_comp[0]) - UP_W'(r_comp[0] * f_comp[2]);
      up_in[2] = UP_W'(r_comp[0] * f_comp[1]) - UP_W'(r_comp[1] * f_comp[0]);
      hd_prod  = (HD_W-1)'(h_clamp) * (HD_W-1)'(dist_ff);
   end

   always_ff @(posedge clock) begin
      up_ff <= up_in;
      hd_ff <= {hd_prod, 1'b0};
   end

   // Whole pipeline moves unless the result register is held
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: screen offsets 2x - W and H - 2y
   logic                    s1_valid_ff;
   logic signed [PIX_W+1:0] ax_ff, ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff <= $signed({1'b0, req_pixel_x, 1'b0}) - $signed({1'b0, w_clamp});
         ay_ff <= $signed({1'b0, h_clamp}) - $signed({1'b0, req_pixel_y, 1'b0});
      end
   end

   // Stage 2: the three products per component
   localparam int PR_W = PIX_W + 2 + COMP_W;
   localparam int PU_W = PIX_W + 2 + UP_W;
   localparam int PF_W = HD_W + 1 + COMP_W;

   logic                    s2_valid_ff;
   logic signed [PR_W-1:0]  pr_ff [3];
   logic signed [PU_W-1:0]  pu_ff [3];
   logic signed [PF_W-1:0]  pf_ff [3];
   logic signed [HD_W:0]    hd_s;

   assign hd_s = $signed({1'b0, hd_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            pr_ff[k] <= ax_ff * r_comp[k];
            pu_ff[k] <= ay_ff * up_ff[k];
            pf_ff[k] <= hd_s * f_comp[k];
         end
      end
   end

   // Stage 3: align to 40 fraction bits and sum
   logic                     s3_valid_ff;
   logic signed [VSUM_W-1:0] v_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            v_ff[k] <= (VSUM_W'(pr_ff[k]) <<< 26) + (VSUM_W'(pu_ff[k]) <<< 12)
                     + (VSUM_W'(pf_ff[k]) <<< 14);
         end
      end
   end

   // Stage 4: sign and magnitude
   logic             s4_valid_ff;
   logic [2:0]       neg4_ff;
   logic [MAG_W-1:0] mag4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            neg4_ff[k] <= v_ff[k][VSUM_W-1];
            mag4_ff[k] <= v_ff[k][VSUM_W-1] ? MAG_W'(-v_ff[k]) : MAG_W'(v_ff[k]);
         end
      end
   end

   // Stage 5: leading one of the largest magnitude
   logic             s5_valid_ff, zero5_ff;
   logic [2:0]       neg5_ff;
   logic [MAG_W-1:0] mag5_ff [3];
   logic [POS_W-1:0] pos_in, pos5_ff;
   logic [MAG_W-1:0] mag_or;

   always_comb begin
      mag_or = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      pos_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mag_or[i]) begin
            pos_in = POS_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag5_ff  <= mag4_ff;
         neg5_ff  <= neg4_ff;
         pos5_ff  <= pos_in;
         zero5_ff <= (mag_or == '0);
      end
   end

   // Stage 6: shift so the largest magnitude lands in [2^29, 2^30)
   logic              s6_valid_ff, zero6_ff;
   logic [2:0]        neg6_ff;
   logic [NORM_W-1:0] mag6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            if (pos5_ff >= POS_W'(NORM_TOP)) begin
               mag6_ff[k] <= NORM_W'(mag5_ff[k] >> (pos5_ff - POS_W'(NORM_TOP)));
            end else begin
               mag6_ff[k] <= NORM_W'(mag5_ff[k] << (POS_W'(NORM_TOP) - pos5_ff));
            end
         end
         neg6_ff  <= neg5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   // Stage 7: squares
   logic                s7_valid_ff;
   logic [2*NORM_W-1:0] sq7_ff [3];
   norm_side_type       side7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            sq7_ff[k]       <= mag6_ff[k] * mag6_ff[k];
            side7_ff.mag[k] <= mag6_ff[k];
         end
         side7_ff.neg   <= neg6_ff;
         side7_ff.degen <= zero6_ff;
      end
   end

   // Stage 8: sum of squares
   logic             s8_valid_ff;
   logic [SUM_W-1:0] sum8_ff;
   norm_side_type    side8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum8_ff  <= SUM_W'(sq7_ff[0]) + SUM_W'(sq7_ff[1]) + SUM_W'(sq7_ff[2]);
         side8_ff <= side7_ff;
      end
   end

   // Length of the normalized vector
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   norm_side_type     sq_side;

   rayg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s8_valid_ff),
      .in_sum    (sum8_ff),
      .in_side   (side8_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Rounding stage: numerator m*2^14 + n/2
   logic                  pr_valid_ff;
   logic [2:0][NUM_W-1:0] num_ff;
   logic [ROOT_W-1:0]     den_ff;
   sign_side_type         sign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (advance) begin
         pr_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= (NUM_W'(sq_side.mag[k]) << FRAC_BITS) + NUM_W'(sq_root >> 1);
         end
         den_ff        <= sq_root;
         sign_ff.neg   <= sq_side.neg;
         sign_ff.degen <= sq_side.degen;
      end
   end

   // Per-component divide by the length
   logic                  dv_valid;
   logic [2:0][QUO_W-1:0] dv_quo;
   sign_side_type         dv_side;

   rayg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pr_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (sign_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output register: restore sign, zero a degenerate vector
   logic                 rsp_valid_ff, rsp_degen_ff;
   logic [DIR_W-1:0]     dir_in [3];
   logic [DIR_W-1:0]     dir_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         priority if (dv_side.degen) begin
            dir_in[k] = '0;
         end else if (dv_side.neg[k]) begin
            dir_in[k] = DIR_W'(0) - DIR_W'(dv_quo[k]);
         end else begin
            dir_in[k] = DIR_W'(dv_quo[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dir_ff       <= dir_in;
         rsp_degen_ff <= dv_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dir_x      = dir_ff[0];
   assign rsp_dir_y      = dir_ff[1];
   assign rsp_dir_z      = dir_ff[2];
   assign rsp_degenerate = rsp_degen_ff;

   // Checks
   localparam logic signed [DIR_W-1:0] UNIT = DIR_W'(2 ** FRAC_BITS);

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0)
      else $error("degenerate item with nonzero direction");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         $signed(rsp_dir_x) <= UNIT && $signed(rsp_dir_x) >= -UNIT &&
         $signed(rsp_dir_y) <= UNIT && $signed(rsp_dir_y) >= -UNIT &&
         $signed(rsp_dir_z) <= UNIT && $signed(rsp_dir_z) >= -UNIT)
      else $error("direction component beyond unit range");

   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff && !zero6_ff |->
         mag6_ff[0][NORM_TOP] || mag6_ff[1][NORM_TOP] || mag6_ff[2][NORM_TOP])
      else $error("normalizing shift missed the top bit");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_valid && !sq_side.degen |-> sq_root[ROOT_W-1:ROOT_W-2] != '0)
      else $error("vector length below normalized range");

endmodule

// ----- sv/rayg_isqrt.sv -----
// ----------------------------------------------------------------------------
// rayg_isqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
module rayg_isqrt import rayg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  norm_side_type     in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output norm_side_type     out_side
);

   logic [REM_W-1:0]  rem_st   [ROOT_W+1];
   logic [ROOT_W-1:0] root_st  [ROOT_W+1];
   logic              valid_st [ROOT_W+1];
   norm_side_type     side_st  [ROOT_W+1];

   assign rem_st[0]   = REM_W'(in_sum);
   assign root_st[0]  = '0;
   assign valid_st[0] = in_valid;
   assign side_st[0]  = in_side;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      localparam int B = ROOT_W - 1 - i;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in, rem_ff;
      logic [ROOT_W-1:0] root_in, root_ff;
      logic              valid_ff;
      norm_side_type     side_ff;

      // Try to set this root bit: (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
      assign trial = (REM_W'(root_st[i]) << (B + 1)) + (REM_W'(1) << (2 * B));

      always_comb begin
         if (rem_st[i] >= trial) begin
            rem_in  = rem_st[i] - trial;
            root_in = root_st[i] | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_st[i];
            root_in = root_st[i];
         end
      end

      // Advance the stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= valid_st[i];
         end
      end

      // Advance the stage payload
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_st[i];
         end
      end

      assign rem_st[i+1]   = rem_ff;
      assign root_st[i+1]  = root_ff;
      assign valid_st[i+1] = valid_ff;
      assign side_st[i+1]  = side_ff;
   end

   assign out_valid = valid_st[ROOT_W];
   assign out_root  = root_st[ROOT_W];
   assign out_side  = side_st[ROOT_W];

endmodule

// ----- sv/rayg_div.sv -----
// ----------------------------------------------------------------------------
// rayg_div
// Pipelined restoring divider for three lanes sharing one divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module rayg_div import rayg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2:0][NUM_W-1:0]  in_num,
   input  logic [ROOT_W-1:0]      in_den,
   input  sign_side_type          in_side,
   output logic                   out_valid,
   output logic [2:0][QUO_W-1:0]  out_quo,
   output sign_side_type          out_side
);

   logic [2:0][NUM_W-1:0] rem_st   [QUO_W+1];
   logic [2:0][QUO_W-1:0] quo_st   [QUO_W+1];
   logic [ROOT_W-1:0]     den_st   [QUO_W+1];
   logic                  valid_st [QUO_W+1];
   sign_side_type         side_st  [QUO_W+1];

   assign rem_st[0]   = in_num;
   assign quo_st[0]   = '0;
   assign den_st[0]   = in_den;
   assign valid_st[0] = in_valid;
   assign side_st[0]  = in_side;

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      localparam int B = QUO_W - 1 - i;
      logic [NUM_W:0]        shifted;
      logic [2:0][NUM_W-1:0] rem_in, rem_ff;
      logic [2:0][QUO_W-1:0] quo_in, quo_ff;
      logic [ROOT_W-1:0]     den_ff;
      logic                  valid_ff;
      sign_side_type         side_ff;

      assign shifted = (NUM_W+1)'(den_st[i]) << B;

      // Subtract the shifted divisor where it fits
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if ({1'b0, rem_st[i][k]} >= shifted) begin
               rem_in[k] = rem_st[i][k] - shifted[NUM_W-1:0];
               quo_in[k] = quo_st[i][k] | (QUO_W'(1) << B);
            end else begin
               rem_in[k] = rem_st[i][k];
               quo_in[k] = quo_st[i][k];
            end
         end
      end

      // Advance the stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= valid_st[i];
         end
      end

      // Advance the stage payload
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            den_ff  <= den_st[i];
            side_ff <= side_st[i];
         end
      end

      assign rem_st[i+1]   = rem_ff;
      assign quo_st[i+1]   = quo_ff;
      assign den_st[i+1]   = den_ff;
      assign valid_st[i+1] = valid_ff;
      assign side_st[i+1]  = side_ff;
   end

   assign out_valid = valid_st[QUO_W];
   assign out_quo   = quo_st[QUO_W];
   assign out_side  = side_st[QUO_W];

endmodule
